// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/lpim_pkg.sv =====
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared types and constants for the linear-probe index map.
// ----------------------------------------------------------------------------
`default_nettype none

package lpim_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 12;
    localparam int CNT_W  = 13;   // slot counter and slot_limit register
    localparam int LIM_W  = 17;   // compare width, holds MAX_SLOTS up to 131071
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 2'd0,
        CMD_LOOKUP     = 2'd1,
        CMD_LOOKUP_ADD = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } status_t;

    // Sequencer to slot allocator
    typedef struct packed {
        logic clr;    // reset the slot count
        logic take;   // allocate one slot
    } alloc_ctrl_t;

    // Slot allocator to sequencer
    typedef struct packed {
        logic             exhausted;
        logic [CNT_W-1:0] used;
    } alloc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_probe_index_map_core.sv =====
// Lookup/add: probes 1..TABLE_ENTRIES entries with busy high, one RAM
//   read per cycle through the single read port.
// Zero key: result strobe the next cycle, busy stays low.
// Clear: busy during the pass, one entry zeroed per cycle on the RAM write port.
// Reset: same clearing pass with busy high; no result strobe.
// Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// linear_probe_index_map_core
// Open-addressing hash table with linear probing, mapping keys to dense slots.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module linear_probe_index_map_core #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_SLOTS     = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lpim_pkg::CMD_W-1:0]    command,
    input  wire logic [lpim_pkg::KEY_W-1:0]    key,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lpim_pkg::CNT_W-1:0]    cfg_wr_data,
    output logic                               result_valid,
    output logic [lpim_pkg::STAT_W-1:0]        status,
    output logic [lpim_pkg::SLOT_W-1:0]        slot,
    output logic                               newly_added
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int ENT_W = lpim_pkg::KEY_W + lpim_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLEAR = 3'b010,
        S_PROBE = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    lpim_pkg::cmd_t                cmd_reg;
    logic [lpim_pkg::KEY_W-1:0]    key_reg;
    logic [IDX_W-1:0]              issue_idx_reg;
    logic [IDX_W-1:0]              chk_idx_reg;
    logic                          chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]              chk_cnt_reg;
    logic [IDX_W-1:0]              clr_idx_reg;
    logic                          clr_cmd_reg;
    logic                          res_vld_reg, res_vld_next;
    lpim_pkg::status_t             res_status_reg, res_status_next;
    logic [lpim_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                          res_added_reg, res_added_next;

    logic                          accept;
    logic                          ram_wr_en;
    logic [IDX_W-1:0]              ram_wr_addr;
    logic [ENT_W-1:0]              ram_wr_data;
    logic [ENT_W-1:0]              ram_rd_data;
    logic [lpim_pkg::KEY_W-1:0]    ent_key;
    logic [lpim_pkg::SLOT_W-1:0]   ent_slot;
    logic                          hit;
    logic                          have_pos;
    logic                          probe_done;
    logic                          add_path;
    lpim_pkg::alloc_ctrl_t         alloc_ctrl;
    lpim_pkg::alloc_stat_t         alloc_stat;

    // Entry store: key in the upper bits, slot in the lower bits
    lpim_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (issue_idx_reg),
        .rd_data (ram_rd_data)
    );

    lpim_slot_alloc #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_alloc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (alloc_ctrl),
        .stat        (alloc_stat)
    );

    // Entry compare on the data read last cycle
    assign ent_key    = ram_rd_data[lpim_pkg::SLOT_W +: lpim_pkg::KEY_W];
    assign ent_slot   = ram_rd_data[lpim_pkg::SLOT_W-1:0];
    assign hit        = (ent_key == key_reg);
    assign have_pos   = hit || (ent_key == '0);
    assign probe_done = (state_reg == S_PROBE) && chk_vld_reg && (have_pos || (&chk_cnt_reg));
    assign add_path   = (cmd_reg == lpim_pkg::CMD_ADD) ||
                        ((cmd_reg == lpim_pkg::CMD_LOOKUP_ADD) && !hit);

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        chk_vld_next    = 1'b0;
        res_vld_next    = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_added_next  = res_added_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_data     = {key_reg, alloc_stat.used[lpim_pkg::SLOT_W-1:0]};
        alloc_ctrl      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == lpim_pkg::CMD_CLEAR)
                    begin
                        state_next     = S_CLEAR;
                        alloc_ctrl.clr = 1'b1;
                    end
                    else if (key == '0)
                    begin
                        res_vld_next    = 1'b1;
                        res_status_next = lpim_pkg::ST_ZERO_KEY;
                        res_slot_next   = '0;
                        res_added_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end

            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_idx_reg;
                ram_wr_data = '0;
                if (&clr_idx_reg)
                begin
                    state_next = S_IDLE;
                    if (clr_cmd_reg)
                    begin
                        res_vld_next    = 1'b1;
                        res_status_next = lpim_pkg::ST_OK;
                        res_slot_next   = '0;
                        res_added_next  = 1'b0;
                    end
                end
            end

            S_PROBE:
            begin
                chk_vld_next = !probe_done;
                if (probe_done)
                begin
                    state_next     = S_IDLE;
                    res_vld_next   = 1'b1;
                    res_slot_next  = '0;
                    res_added_next = 1'b0;
                    if (add_path)
                    begin
                        if (alloc_stat.exhausted)
                        begin
                            res_status_next = lpim_pkg::ST_EXHAUSTED;
                        end
                        else if (!have_pos)
                        begin
                            res_status_next = lpim_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_status_next = lpim_pkg::ST_OK;
                            res_slot_next   = alloc_stat.used[lpim_pkg::SLOT_W-1:0];
                            res_added_next  = 1'b1;
                            ram_wr_en       = 1'b1;
                            alloc_ctrl.take = 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        res_status_next = lpim_pkg::ST_OK;
                        res_slot_next   = ent_slot;
                    end
                    else
                    begin
                        res_status_next = lpim_pkg::ST_NOT_FOUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            chk_vld_reg <= 1'b0;
            chk_cnt_reg <= '0;
            clr_idx_reg <= '0;
            clr_cmd_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            res_vld_reg <= res_vld_next;
            if (accept)
            begin
                chk_cnt_reg <= '0;
            end
            else if (chk_vld_reg)
            begin
                chk_cnt_reg <= chk_cnt_reg + 1'b1;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (accept && (command == lpim_pkg::CMD_CLEAR))
            begin
                clr_cmd_reg <= 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= lpim_pkg::cmd_t'(command);
            key_reg       <= key;
            issue_idx_reg <= key[IDX_W-1:0];
        end
        else
        begin
            issue_idx_reg <= issue_idx_reg + 1'b1;
        end
        chk_idx_reg    <= issue_idx_reg;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_added_reg  <= res_added_next;
    end

    assign result_valid = res_vld_reg;
    assign status       = res_status_reg;
    assign slot         = res_slot_reg;
    assign newly_added  = res_added_reg;

    // Checks
    `ASSERT_IMPLY(a_result_when_idle, clk, rst_n, result_valid, !busy,
        "result strobe while busy")
    `ASSERT_IMPLY(a_error_clean, clk, rst_n,
        result_valid && (status != lpim_pkg::ST_OK), (slot == '0) && !newly_added,
        "error result carries slot or add flag")
    `ASSERT_NEXT(a_probe_busy, clk, rst_n,
        accept && (command != lpim_pkg::CMD_CLEAR) && (key != '0), busy && !result_valid,
        "probe request did not enter the probe sequence")

endmodule

`default_nettype wire

// ===== rtl/core/lpim_ram.sv =====
// ----------------------------------------------------------------------------
// lpim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpim_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpim_slot_alloc.sv =====
// ----------------------------------------------------------------------------
// lpim_slot_alloc
// Slot counter, slot_limit register and the exhausted check.
// ----------------------------------------------------------------------------
`default_nettype none

module lpim_slot_alloc #(
    parameter int MAX_SLOTS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lpim_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire lpim_pkg::alloc_ctrl_t         ctrl,
    output lpim_pkg::alloc_stat_t              stat
);

    localparam logic [lpim_pkg::LIM_W-1:0] MAX_LIM = lpim_pkg::LIM_W'(MAX_SLOTS);

    logic [lpim_pkg::CNT_W-1:0] limit_reg;
    logic [lpim_pkg::CNT_W-1:0] used_reg;
    logic [lpim_pkg::CNT_W-1:0] used_next;
    logic [lpim_pkg::LIM_W-1:0] eff_lim;

    // effective limit is min(slot_limit, MAX_SLOTS)
    always_comb
    begin
        eff_lim = lpim_pkg::LIM_W'(limit_reg);
        if (eff_lim > MAX_LIM)
        begin
            eff_lim = MAX_LIM;
        end
    end

    assign stat.exhausted = (lpim_pkg::LIM_W'(used_reg) >= eff_lim);
    assign stat.used      = used_reg;

    // count update; clear wins
    always_comb
    begin
        used_next = used_reg;
        if (ctrl.clr)
        begin
            used_next = '0;
        end
        else if (ctrl.take)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lpim_pkg::SLOT_LIMIT_RST;
            used_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/linear_probe_index_map_checker.sv =====
// ----------------------------------------------------------------------------
// linear_probe_index_map_checker
// Watches the request, configuration and result channels of the index map.
// Keeps its own copy of the probe table, slot counter and slot limit, works
// out the answer to every accepted request, and compares each result strobe
// field by field with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module linear_probe_index_map_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [lpim_pkg::CMD_W-1:0]    command,
    input  logic [lpim_pkg::KEY_W-1:0]    key,
    input  logic                          cfg_wr_en,
    input  logic [lpim_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          result_valid,
    input  logic [lpim_pkg::STAT_W-1:0]   status,
    input  logic [lpim_pkg::SLOT_W-1:0]   slot,
    input  logic                          newly_added,
    output int                            mismatches,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES  = 4096;
    localparam int SLOT_CAP = 4096;

    typedef struct packed {
        lpim_pkg::cmd_t                req;
        logic [lpim_pkg::KEY_W-1:0]    req_key;
        lpim_pkg::status_t             code;
        logic [lpim_pkg::SLOT_W-1:0]   slot_no;
        logic                          added;
    } answer_t;

    // Shadow of the table and allocator
    logic [lpim_pkg::KEY_W-1:0]  bucket_key  [ENTRIES];
    logic [lpim_pkg::SLOT_W-1:0] bucket_slot [ENTRIES];
    logic [lpim_pkg::CNT_W-1:0]  slots_taken;
    logic [lpim_pkg::CNT_W-1:0]  limit_reg;

    // Answers waiting for their result strobe, oldest first
    answer_t answers[$];

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Linear probe from the home bucket; stops at an empty or matching entry
    function automatic bit find_entry(input logic [lpim_pkg::KEY_W-1:0] k,
                                      output int where);
        int idx;
        where = 0;
        for (int off = 0; off < ENTRIES; off++) begin
            idx = (int'(k % ENTRIES) + off) % ENTRIES;
            if (bucket_key[idx] == '0 || bucket_key[idx] == k) begin
                where = idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Slot count is checked against the limit before the free entry
    function automatic lpim_pkg::status_t allocate(input logic [lpim_pkg::KEY_W-1:0] k,
                                                   input bit found, input int where,
                                                   output logic [lpim_pkg::SLOT_W-1:0] s);
        int lim;
        s = '0;
        lim = (int'(limit_reg) > SLOT_CAP) ? SLOT_CAP : int'(limit_reg);
        if (int'(slots_taken) >= lim)
            return lpim_pkg::ST_EXHAUSTED;
        if (!found)
            return lpim_pkg::ST_FULL;
        s = slots_taken[lpim_pkg::SLOT_W-1:0];
        slots_taken++;
        bucket_key[where]  = k;
        bucket_slot[where] = s;
        return lpim_pkg::ST_OK;
    endfunction

    function automatic answer_t map_key_request(input lpim_pkg::cmd_t c,
                                                input logic [lpim_pkg::KEY_W-1:0] k);
        answer_t a;
        bit found;
        int where;
        a = '{req: c, req_key: k, code: lpim_pkg::ST_OK, slot_no: '0, added: 1'b0};
        if (c == lpim_pkg::CMD_CLEAR) begin
            foreach (bucket_key[i])
                bucket_key[i] = '0;
            slots_taken = '0;
        end
        else if (k == '0) begin
            a.code = lpim_pkg::ST_ZERO_KEY;
        end
        else begin
            found = find_entry(k, where);
            if (c == lpim_pkg::CMD_ADD) begin
                a.code  = allocate(k, found, where, a.slot_no);
                a.added = (a.code == lpim_pkg::ST_OK);
            end
            else if (found && bucket_key[where] == k) begin
                a.slot_no = bucket_slot[where];
            end
            else if (c == lpim_pkg::CMD_LOOKUP) begin
                a.code = lpim_pkg::ST_NOT_FOUND;
            end
            else begin
                a.code  = allocate(k, found, where, a.slot_no);
                a.added = (a.code == lpim_pkg::ST_OK);
            end
            if (a.code != lpim_pkg::ST_OK)
                a.slot_no = '0;
        end
        return a;
    endfunction

    // Compare results, track config writes, predict accepted requests
    always @(posedge clk) begin
        answer_t want;
        if (!rst_n) begin
            answers.delete();
            foreach (bucket_key[i]) begin
                bucket_key[i]  = '0;
                bucket_slot[i] = '0;
            end
            slots_taken = '0;
            limit_reg   = lpim_pkg::SLOT_LIMIT_RST;
            mismatches  = 0;
        end
        else begin
            if (result_valid) begin
                if (answers.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with no request outstanding: status %0d slot %0d added %0b",
                        status, slot, newly_added));
                end
                else begin
                    want = answers.pop_front();
                    if (status !== want.code)
                        report_mismatch($sformatf("%s key %h: status %0d, want %0d",
                            want.req.name(), want.req_key, status, want.code));
                    if (slot !== want.slot_no)
                        report_mismatch($sformatf("%s key %h: slot %0d, want %0d",
                            want.req.name(), want.req_key, slot, want.slot_no));
                    if (newly_added !== want.added)
                        report_mismatch($sformatf("%s key %h: newly_added %b, want %b",
                            want.req.name(), want.req_key, newly_added, want.added));
                end
            end
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
            if (start && !busy)
                answers.push_back(map_key_request(lpim_pkg::cmd_t'(command), key));
        end
        pending = answers.size();
    end

endmodule

// ===== dv/linear_probe_index_map_core_test.sv =====
// ----------------------------------------------------------------------------
// linear_probe_index_map_core_test
// Drives requests and slot_limit writes into the index map: a directed set of
// corner cases and random phases over several limits with clustered, repeated
// and wrapping keys. The checker predicts and compares; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module linear_probe_index_map_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PHASES         = 8;
    localparam int          PHASE_REQUESTS = 210;
    localparam int          POOL_DEPTH     = 48;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           start       = 1'b0;
    logic [lpim_pkg::CMD_W-1:0]     command     = lpim_pkg::CMD_ADD;
    logic [lpim_pkg::KEY_W-1:0]     key         = '0;
    logic                           cfg_wr_en   = 1'b0;
    logic [lpim_pkg::CNT_W-1:0]     cfg_wr_data = '0;
    logic                           busy;
    logic                           result_valid;
    logic [lpim_pkg::STAT_W-1:0]    status;
    logic [lpim_pkg::SLOT_W-1:0]    slot;
    logic                           newly_added;

    int                             mismatches;
    int                             pending;
    int unsigned                    cycles = 0;

    // Recently mapped keys, reused to hit existing entries
    logic [lpim_pkg::KEY_W-1:0]     key_pool[$];
    logic [lpim_pkg::SLOT_W-1:0]    cluster_base;

    always #6 clk = ~clk;

    linear_probe_index_map_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .status       (status),
        .slot         (slot),
        .newly_added  (newly_added)
    );

    linear_probe_index_map_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .key          (key),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .status       (status),
        .slot         (slot),
        .newly_added  (newly_added),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("linear_probe_index_map_core_test: FAIL");
            $finish;
        end
    end

    // One request; start stays high when the next one follows without a gap.
    // busy only moves at the rising edge, so its value here holds for the next edge.
    task automatic issue(input lpim_pkg::cmd_t c, input logic [lpim_pkg::KEY_W-1:0] k);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        command <= c;
        key     <= k;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    // slot_limit is written only once every request has been answered
    task automatic write_limit(input logic [lpim_pkg::CNT_W-1:0] value);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [lpim_pkg::KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (roll < 65)
            return {20'($urandom), 12'(cluster_base + $urandom_range(0, 23))};
        if (roll < 90)
            return $urandom;
        if (roll < 95)
            return '0;
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0001;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h0000_1000;
        endcase
    endfunction

    function automatic lpim_pkg::cmd_t pick_cmd();
        int roll;
        roll = $urandom_range(0, 199);
        if (roll < 3)
            return lpim_pkg::CMD_CLEAR;
        if (roll < 63)
            return lpim_pkg::CMD_ADD;
        if (roll < 123)
            return lpim_pkg::CMD_LOOKUP;
        return lpim_pkg::CMD_LOOKUP_ADD;
    endfunction

    initial begin
        logic [lpim_pkg::CNT_W-1:0] limit_plan [PHASES];
        lpim_pkg::cmd_t             c;
        logic [lpim_pkg::KEY_W-1:0] k;

        limit_plan = '{13'd8191, 13'd0, 13'd5, 13'd4096, 13'd4095, 13'd100, 13'd1, 13'd2000};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero key, collisions, wrap-around, rebind, clear
        issue(lpim_pkg::CMD_ADD,        32'h0000_0000);
        issue(lpim_pkg::CMD_LOOKUP,     32'h0000_0000);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_0000);
        issue(lpim_pkg::CMD_CLEAR,      32'h0000_0000);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0001);
        issue(lpim_pkg::CMD_ADD,        32'hFFFF_FFFF);
        issue(lpim_pkg::CMD_ADD,        32'h0000_1FFF);   // home bucket taken, wraps to entry 0
        issue(lpim_pkg::CMD_LOOKUP,     32'h0000_1FFF);
        issue(lpim_pkg::CMD_LOOKUP,     32'h0000_1001);   // collides with key 1, then misses
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_1001);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_1001);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0001);   // rebind to a fresh slot
        issue(lpim_pkg::CMD_LOOKUP,     32'h0000_0001);
        issue(lpim_pkg::CMD_LOOKUP,     32'hFFFF_FFFF);
        issue(lpim_pkg::CMD_CLEAR,      $urandom);
        issue(lpim_pkg::CMD_LOOKUP,     32'h0000_0001);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h8000_0000);
        write_limit(13'd0);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0005);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_0006);
        issue(lpim_pkg::CMD_LOOKUP,     32'h8000_0000);
        write_limit(13'd1);
        issue(lpim_pkg::CMD_CLEAR,      32'h0000_0000);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0007);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0007);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_0007);

        // Random phases, one slot_limit setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            write_limit((ph == PHASES - 1) ? 13'($urandom_range(0, 8191)) : limit_plan[ph]);
            cluster_base = (ph % 2 == 1) ? 12'd4088 : 12'($urandom);
            if ($urandom_range(0, 1) == 1)
                issue(lpim_pkg::CMD_CLEAR, $urandom);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                c = pick_cmd();
                k = pick_key();
                issue(c, k);
                if ((c == lpim_pkg::CMD_ADD || c == lpim_pkg::CMD_LOOKUP_ADD) && k != '0) begin
                    key_pool.push_back(k);
                    if (key_pool.size() > POOL_DEPTH)
                        key_pool.delete($urandom_range(0, POOL_DEPTH - 1));
                end
            end
        end

        // Limit above the slot count, then clear and add again
        write_limit(13'd8191);
        issue(lpim_pkg::CMD_ADD,        32'h0000_0FFF);
        issue(lpim_pkg::CMD_CLEAR,      $urandom);
        issue(lpim_pkg::CMD_LOOKUP_ADD, 32'h0000_0FFF);

        // Drain
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("linear_probe_index_map_core_test: PASS");
        else
            $display("linear_probe_index_map_core_test: FAIL");
        $finish;
    end

endmodule
